// ===== rtl/degree_index_sorter_defines.svh =====
// Assertion macros used by the degree index sorter RTL.
`ifndef DEGREE_INDEX_SORTER_DEFINES_SVH
`define DEGREE_INDEX_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dis_pkg.sv =====
// Types, constants and helpers shared by the degree index sorter modules.
package dis_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int DEGREE_BITS  = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // Fixed port widths.
  localparam int DEGREE_W = 16;
  localparam int INDEX_W  = 6;
  localparam int MODE_W   = 2;

  // Order mode codes.
  localparam logic [MODE_W-1:0] MODE_DESC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO = 2'd2;

  // One stored vertex: its degree and its arrival index.
  typedef struct packed {
    logic [DEGREE_BITS-1:0] key;
    logic [ADDR_W-1:0]      idx;
  } entry_t;

  // Access request from the sequencer to the vertex memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP,
    S_WR,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_ESTART,
    S_EOUT
  } state_t;

endpackage

// ===== rtl/degree_index_sorter.sv =====
// Insertion: an accepted item moves each smaller stored entry one place down (s up to 63), then is written.
// Once the last item is written or dropped, results are read in S_ESTART and S_EOUT (after S_P0 to S_P4 in auto mode).
// Throughput is set by the single read and write port of the vertex memory: one entry a cycle
// while the output is not stalled, so a full set of n vertices streams out without gaps.
// Reset (synchronous, active high) empties the set, clears overflow and selects descending order.
// Top level of the degree index sorter: mode register, sequencer and vertex memory.
module degree_index_sorter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dis_pkg::MODE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dis_pkg::DEGREE_W-1:0]  degree,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dis_pkg::INDEX_W-1:0]   vertex_index,
  output logic [dis_pkg::DEGREE_W-1:0]  vertex_degree,
  output logic                          end_of_list,
  output logic                          overflow
);
  import dis_pkg::*;

  logic [MODE_W-1:0] order_mode;
  ram_req_t          ram_req;
  entry_t            ram_rdata;

  assign cfg_ready = 1'b1;

  // Order mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= MODE_DESC;
    end else if (cfg_valid && cfg_ready) begin
      order_mode <= cfg_data;
    end
  end

  dis_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .order_mode    (order_mode),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .degree        (degree),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vertex_index  (vertex_index),
    .vertex_degree (vertex_degree),
    .end_of_list   (end_of_list),
    .overflow      (overflow),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata)
  );

  dis_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/dis_ram.sv =====
// Vertex memory: one write port, one read port with registered read data.
module dis_ram (
  input  logic              clk,
  input  dis_pkg::ram_req_t req,
  output dis_pkg::entry_t   rdata
);
  import dis_pkg::*;

  entry_t mem [MAX_VERTICES];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/dis_seq.sv =====
// Sequencer: insertion into the sorted memory, order decision and result output.
`include "degree_index_sorter_defines.svh"

module dis_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dis_pkg::MODE_W-1:0]    order_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dis_pkg::DEGREE_W-1:0]  degree,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dis_pkg::INDEX_W-1:0]   vertex_index,
  output logic [dis_pkg::DEGREE_W-1:0]  vertex_degree,
  output logic                          end_of_list,
  output logic                          overflow,
  output dis_pkg::ram_req_t             ram_req,
  input  dis_pkg::entry_t               ram_rdata
);
  import dis_pkg::*;

  // Control registers.
  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic                 ovf, ovf_next;
  logic                 out_valid_next;

  // Working registers.
  logic [DEGREE_BITS-1:0] key, key_next;
  logic                   last_r, last_r_next;
  logic [ADDR_W-1:0]      pos, pos_next;
  logic [CNT_W-1:0]       k, k_next;
  logic                   rev, rev_next;
  logic [ADDR_W-1:0]      i0, i0_next;
  logic [ADDR_W-1:0]      hi, hi_next;
  logic signed [ADDR_W:0] front, front_next;

  // Output payload registers.
  logic [INDEX_W-1:0]   vertex_index_next;
  logic [DEGREE_W-1:0]  vertex_degree_next;
  logic                 end_of_list_next;
  logic                 overflow_next;

  logic                 out_free;
  logic                 eol;
  logic                 load_eol;
  logic [CNT_W-1:0]     n_fin;

  // Signed difference of two arrival indices.
  function automatic logic signed [ADDR_W:0] idx_diff(input logic [ADDR_W-1:0] a,
                                                      input logic [ADDR_W-1:0] b);
    idx_diff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // Memory address of output position kk, forward or reversed.
  function automatic logic [ADDR_W-1:0] src_addr(input logic [CNT_W-1:0] kk,
                                                 input logic [CNT_W-1:0] n,
                                                 input logic r);
    logic [CNT_W-1:0] back;
    back = n - kk - CNT_W'(1);
    src_addr = r ? back[ADDR_W-1:0] : kk[ADDR_W-1:0];
  endfunction

  // First state after a set closes with n stored vertices.
  function automatic state_t close_state(input logic [CNT_W-1:0] n,
                                         input logic [MODE_W-1:0] mode);
    if (mode == MODE_AUTO && n >= CNT_W'(2)) begin
      close_state = S_P0;
    end else begin
      close_state = S_ESTART;
    end
  endfunction

  assign out_free = !out_valid || out_ready;
  assign n_fin    = count + CNT_W'(1);
  assign eol      = (k == count - CNT_W'(1));
  assign load_eol = (state == S_EOUT) && out_free && eol;

  // Next state, memory requests and output loading.
  always_comb begin
    state_next         = state;
    count_next         = count;
    ovf_next           = ovf;
    key_next           = key;
    last_r_next        = last_r;
    pos_next           = pos;
    k_next             = k;
    rev_next           = rev;
    i0_next            = i0;
    hi_next            = hi;
    front_next         = front;
    out_valid_next     = out_valid && !out_ready;
    vertex_index_next  = vertex_index;
    vertex_degree_next = vertex_degree;
    end_of_list_next   = end_of_list;
    overflow_next      = overflow;
    in_ready           = 1'b0;
    ram_req            = '0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_next    = degree[DEGREE_BITS-1:0];
          last_r_next = last;
          if (count < CNT_W'(MAX_VERTICES)) begin
            pos_next = count[ADDR_W-1:0];
            if (count != '0) begin
              // Fetch the tail entry to compare against.
              ram_req.re    = 1'b1;
              ram_req.raddr = ADDR_W'(count - CNT_W'(1));
              state_next    = S_CMP;
            end else begin
              state_next = S_WR;
            end
          end else begin
            // Memory full: the item is dropped.
            ovf_next = 1'b1;
            if (last) begin
              k_next     = '0;
              rev_next   = (order_mode == MODE_ASC);
              state_next = close_state(count, order_mode);
            end
          end
        end
      end

      S_CMP: begin
        ram_req.we = 1'b1;
        ram_req.waddr = pos;
        if (ram_rdata.key < key) begin
          // Move the smaller entry one place down and look one place up.
          ram_req.wdata = ram_rdata;
          pos_next      = pos - ADDR_W'(1);
          if (pos > ADDR_W'(1)) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = pos - ADDR_W'(2);
          end else begin
            state_next = S_WR;
          end
        end else begin
          // Slot found: store the new vertex here.
          ram_req.wdata.key = key;
          ram_req.wdata.idx = count[ADDR_W-1:0];
          count_next        = n_fin;
          if (last_r) begin
            k_next     = '0;
            rev_next   = (order_mode == MODE_ASC);
            state_next = close_state(n_fin, order_mode);
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_WR: begin
        ram_req.we        = 1'b1;
        ram_req.waddr     = pos;
        ram_req.wdata.key = key;
        ram_req.wdata.idx = count[ADDR_W-1:0];
        count_next        = n_fin;
        if (last_r) begin
          k_next     = '0;
          rev_next   = (order_mode == MODE_ASC);
          state_next = close_state(n_fin, order_mode);
        end else begin
          state_next = S_IDLE;
        end
      end

      // Auto mode: read the first two and last two indices of the list.
      S_P0: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
        state_next    = S_P1;
      end

      S_P1: begin
        i0_next       = ram_rdata.idx;
        ram_req.re    = 1'b1;
        ram_req.raddr = ADDR_W'(1);
        state_next    = S_P2;
      end

      S_P2: begin
        front_next    = idx_diff(i0, ram_rdata.idx);
        ram_req.re    = 1'b1;
        ram_req.raddr = ADDR_W'(count - CNT_W'(2));
        state_next    = S_P3;
      end

      S_P3: begin
        hi_next       = ram_rdata.idx;
        ram_req.re    = 1'b1;
        ram_req.raddr = ADDR_W'(count - CNT_W'(1));
        state_next    = S_P4;
      end

      S_P4: begin
        rev_next   = (front < idx_diff(hi, ram_rdata.idx));
        state_next = S_ESTART;
      end

      S_ESTART: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = src_addr(k, count, rev);
        state_next    = S_EOUT;
      end

      S_EOUT: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          vertex_index_next  = INDEX_W'(ram_rdata.idx);
          vertex_degree_next = DEGREE_W'(ram_rdata.key);
          end_of_list_next   = eol;
          overflow_next      = ovf;
          if (eol) begin
            // Set delivered: clear for the next one.
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_IDLE;
          end else begin
            k_next        = k + CNT_W'(1);
            ram_req.re    = 1'b1;
            ram_req.raddr = src_addr(k + CNT_W'(1), count, rev);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    key           <= key_next;
    last_r        <= last_r_next;
    pos           <= pos_next;
    k             <= k_next;
    rev           <= rev_next;
    i0            <= i0_next;
    hi            <= hi_next;
    front         <= front_next;
    vertex_index  <= vertex_index_next;
    vertex_degree <= vertex_degree_next;
    end_of_list   <= end_of_list_next;
    overflow      <= overflow_next;
  end

  // Checks on the sequencer.
  `DIS_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(MAX_VERTICES), "item count above capacity")
  `DIS_ASSERT_NOW(a_no_same_addr, clk, rst, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "read and write to one entry")
  `DIS_ASSERT_NOW(a_shift_pos, clk, rst, state == S_CMP, pos != '0, "compare step at top of list")
  `DIS_ASSERT_NEXT(a_set_clear, clk, rst, load_eol, count == '0 && !ovf, "set not cleared after last result")

endmodule

// ===== test/degree_index_sorter_tb.sv =====
// Self-checking testbench for the degree index sorter: directed, capacity and random sets.
module degree_index_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dis_pkg::*;

  // Mode code 3 is not defined by the block and must act as descending.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_VERTICES = 125;

  typedef struct {
    logic [INDEX_W-1:0]  vidx;
    logic [DEGREE_W-1:0] vdeg;
    logic                eol;
    logic                ovf;
  } sorted_vertex_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [MODE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DEGREE_W-1:0]  degree = '0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [INDEX_W-1:0]   vertex_index;
  logic [DEGREE_W-1:0]  vertex_degree;
  logic                 end_of_list;
  logic                 overflow;

  // Predictor state: the stable descending chain of the open set.
  logic [DEGREE_W-1:0]  chain_key [MAX_VERTICES];
  logic [INDEX_W-1:0]   chain_idx [MAX_VERTICES];
  int                   chain_count = 0;
  bit                   chain_dropped = 1'b0;
  logic [MODE_W-1:0]    pred_mode = MODE_DESC;
  sorted_vertex_t       sorted_pending_q[$];

  int  errors = 0;
  int  vertices_sent = 0;
  int  results_seen = 0;
  int  sets_closed = 0;
  int  overflow_sets = 0;
  int  sets_per_mode [4] = '{0, 0, 0, 0};
  bit  back_to_back = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  degree_index_sorter u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .degree        (degree),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vertex_index  (vertex_index),
    .vertex_degree (vertex_degree),
    .end_of_list   (end_of_list),
    .overflow      (overflow)
  );

  always #5 clk = ~clk;

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Predict one accepted vertex; the last one releases the whole sorted set.
  function automatic void predict_vertex(input logic [DEGREE_W-1:0] d, input logic l);
    int pos;
    int n;
    int front;
    int back;
    bit rev;
    sorted_vertex_t sv;
    if (chain_count < MAX_VERTICES) begin
      pos = chain_count;
      // Move smaller keys down; equal keys stay ahead of the newcomer.
      while (pos > 0 && chain_key[pos-1] < d) begin
        chain_key[pos] = chain_key[pos-1];
        chain_idx[pos] = chain_idx[pos-1];
        pos--;
      end
      chain_key[pos] = d;
      chain_idx[pos] = INDEX_W'(chain_count);
      chain_count++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (!l) return;

    n = chain_count;
    rev = 1'b0;
    if (pred_mode == MODE_ASC) begin
      rev = 1'b1;
    end else if (pred_mode == MODE_AUTO && n >= 2) begin
      front = int'(chain_idx[0]) - int'(chain_idx[1]);
      back  = int'(chain_idx[n-2]) - int'(chain_idx[n-1]);
      rev   = front < back;
    end
    for (int k = 0; k < n; k++) begin
      pos     = rev ? (n - 1 - k) : k;
      sv.vidx = chain_idx[pos];
      sv.vdeg = chain_key[pos];
      sv.eol  = (k == n - 1);
      sv.ovf  = chain_dropped;
      sorted_pending_q.push_back(sv);
    end
    sets_closed++;
    sets_per_mode[pred_mode]++;
    if (chain_dropped) overflow_sets++;
    chain_count = 0;
    chain_dropped = 1'b0;
  endfunction

  // Send one vertex item; valid stays high afterwards unless a gap follows.
  task automatic send_vertex(input logic [DEGREE_W-1:0] d, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    degree   = d;
    last     = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vertex(d, l);
    vertices_sent++;
    @(negedge clk);
  endtask

  // Wait until every predicted result has arrived and the block has settled.
  task automatic wait_all_sorted();
    in_valid = 1'b0;
    while (sorted_pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the order mode register while the block is idle.
  task automatic set_order_mode(input logic [MODE_W-1:0] m);
    wait_all_sorted();
    cfg_valid = 1'b1;
    cfg_data  = m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_mode = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send a whole set given as a list of degrees; the final one carries last.
  task automatic send_set(input logic [DEGREE_W-1:0] degs[$]);
    foreach (degs[k]) send_vertex(degs[k], k == degs.size() - 1);
  endtask

  function automatic logic [DEGREE_W-1:0] pick_degree(input int style);
    case (style)
      0: return DEGREE_W'($urandom_range(0, 65535));
      1: return DEGREE_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return DEGREE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Reset value of the register, extremes of the degree and ties.
  task automatic test_default_order();
    send_set('{16'd5, 16'hFFFF, 16'd0, 16'd5, 16'd100});
  endtask

  // Ascending, auto and unused mode codes, ties in reverse, and auto mode with small and decisive sets.
  task automatic test_order_modes();
    set_order_mode(MODE_ASC);
    send_set('{16'd7, 16'd7, 16'd3});
    set_order_mode(MODE_AUTO);
    send_set('{16'd42});
    send_set('{16'd5, 16'd9});
    send_set('{16'd30, 16'd20, 16'd0, 16'd10});
    send_set('{16'd10, 16'd0, 16'd30, 16'd20});
    set_order_mode(MODE_UNUSED);
    send_set('{16'd1, 16'd2, 16'd3});
  endtask

  // Full set, one dropped item that closes the set, and several dropped items.
  task automatic test_capacity();
    set_order_mode(MODE_DESC);
    for (int k = 0; k < MAX_VERTICES; k++) send_vertex(pick_degree(1), k == MAX_VERTICES - 1);
    for (int k = 0; k <= MAX_VERTICES; k++) send_vertex(pick_degree(0), k == MAX_VERTICES);
    set_order_mode(MODE_ASC);
    for (int k = 0; k < MAX_VERTICES + 6; k++) send_vertex(pick_degree(2), k == MAX_VERTICES + 5);
  endtask

  // Random sets under random modes; mostly small sets, a few near or past capacity.
  task automatic test_random_sets();
    int start;
    int sets_in_phase;
    int n;
    int style;
    int r;
    start = vertices_sent;
    while (vertices_sent - start < RANDOM_VERTICES) begin
      set_order_mode(MODE_W'($urandom_range(0, 3)));
      back_to_back = ($urandom_range(0, 3) == 0);
      sets_in_phase = $urandom_range(1, 4);
      for (int s = 0; s < sets_in_phase; s++) begin
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(1, 10);
        else if (r < 96) n = $urandom_range(11, 40);
        else n = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 4);
        style = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) send_vertex(pick_degree(style), k == n - 1);
      end
      back_to_back = 1'b0;
    end
  endtask

  // Result side stalls at random.
  always @(negedge clk) begin
    int gap;
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      gap = pick_gap();
      out_ready = (gap == 0);
      stall_left = (gap > 0) ? gap - 1 : 0;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    sorted_vertex_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (sorted_pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result idx=%0d deg=%0d eol=%0b ovf=%0b", $time,
                 vertex_index, vertex_degree, end_of_list, overflow);
      end else begin
        want = sorted_pending_q.pop_front();
        if (vertex_index !== want.vidx) begin
          errors++;
          $display("%0t: vertex_index expected %0d actual %0d", $time, want.vidx, vertex_index);
        end
        if (vertex_degree !== want.vdeg) begin
          errors++;
          $display("%0t: vertex_degree expected %0d actual %0d", $time, want.vdeg,
                   vertex_degree);
        end
        if (end_of_list !== want.eol) begin
          errors++;
          $display("%0t: end_of_list expected %0b actual %0b", $time, want.eol, end_of_list);
        end
        if (overflow !== want.ovf) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
        end
      end
    end
  end

  // Watchdog: too many cycles without any item moving on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_order();
    test_order_modes();
    test_capacity();
    test_random_sets();
    wait_all_sorted();

    $display("Covered %0d vertices in %0d sets (%0d with dropped items), %0d results checked.",
             vertices_sent, sets_closed, overflow_sets, results_seen);
    $display("Sets per order mode: desc %0d, asc %0d, auto %0d, unused code %0d.",
             sets_per_mode[0], sets_per_mode[1], sets_per_mode[2], sets_per_mode[3]);
    if (errors == 0 && sorted_pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
